// ===== sv/double_ended_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended queue checker
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// property that must hold at every sampled edge outside reset
`define DQ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg
// Request and status codes, controller command and status bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dq_pkg;

	typedef logic [1:0] req_t;
	typedef logic [1:0] status_t;

	localparam req_t REQ_PUSH_FRONT = 2'd0;
	localparam req_t REQ_PUSH_BACK  = 2'd1;
	localparam req_t REQ_POP_FRONT  = 2'd2;
	localparam req_t REQ_POP_BACK   = 2'd3;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_POP_EMPTY = 2'd1;
	localparam status_t STATUS_PUSH_FULL = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic exec;
		logic capture;
		logic out_load;
	} dq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_read;
	} dq_sts_t;

endpackage

// ===== sv/dq_ctrl.sv =====
// ---------------------------------------------------------------------------
// dq_ctrl
// Sequencer for one request: accept, update, optional refill read, result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output dq_pkg::dq_cmd_t cmd,
	input  dq_pkg::dq_sts_t sts
);
	import dq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_read ? ST_READ : ST_DONE;
			end
			ST_READ: begin
				cmd.capture = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// result register frees up once the previous item is taken
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/dq_datapath.sv =====
// ---------------------------------------------------------------------------
// dq_datapath
// Slot memory, ring pointers, count, cached end values and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_datapath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dq_pkg::dq_cmd_t              cmd,
	output dq_pkg::dq_sts_t              sts,
	input  dq_pkg::req_t                 req_type,
	input  logic [DATA_WIDTH-1:0]        push_value,
	output logic [DATA_WIDTH-1:0]        popped_value,
	output logic [DATA_WIDTH-1:0]        front_value,
	output logic [DATA_WIDTH-1:0]        back_value,
	output logic [$clog2(DEPTH+1)-1:0]   element_count,
	output logic                         is_empty,
	output logic                         is_full,
	output dq_pkg::status_t              status
);
	import dq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	req_t                  req_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [CW-1:0]         count_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] back_q;
	logic [DATA_WIDTH-1:0] popped_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] rd_data_q;

	logic [AW-1:0] head_prev;
	logic [AW-1:0] head_next;
	logic [AW-1:0] tail_prev;
	logic [AW-1:0] tail_prev2;
	logic          empty_now;
	logic          full_now;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign head_prev  = idx_prev(head_q);
	assign head_next  = idx_next(head_q);
	assign tail_prev  = idx_prev(tail_q);
	assign tail_prev2 = idx_prev(tail_prev);
	assign empty_now  = (count_q == '0);
	assign full_now   = (count_q == FULL_CNT);

	// a pop that leaves elements behind must refill the cached end from memory
	assign sts.need_read = (req_q == REQ_POP_FRONT || req_q == REQ_POP_BACK) &&
	                       (count_q > CW'(1));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q;
		rd_addr = head_next;
		case (req_q)
			REQ_PUSH_FRONT: begin
				wr_en   = cmd.exec && !full_now;
				wr_addr = head_prev;
			end
			REQ_PUSH_BACK: begin
				wr_en   = cmd.exec && !full_now;
				wr_addr = tail_q;
			end
			REQ_POP_FRONT: begin
				rd_addr = head_next;
			end
			REQ_POP_BACK: begin
				rd_addr = tail_prev2;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_en = cmd.exec && sts.need_read;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			case (req_q)
				REQ_PUSH_FRONT: begin
					if (!full_now) begin
						head_q  <= head_prev;
						count_q <= count_q + CW'(1);
					end
				end
				REQ_PUSH_BACK: begin
					if (!full_now) begin
						tail_q  <= idx_next(tail_q);
						count_q <= count_q + CW'(1);
					end
				end
				REQ_POP_FRONT: begin
					if (!empty_now) begin
						head_q  <= head_next;
						count_q <= count_q - CW'(1);
					end
				end
				REQ_POP_BACK: begin
					if (!empty_now) begin
						tail_q  <= tail_prev;
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q   <= req_type;
			value_q <= push_value;
		end
		if (cmd.exec) begin
			popped_q <= '0;
			status_q <= STATUS_OK;
			case (req_q)
				REQ_PUSH_FRONT: begin
					if (full_now) begin
						status_q <= STATUS_PUSH_FULL;
					end else begin
						front_q <= value_q;
						if (empty_now) begin
							back_q <= value_q;
						end
					end
				end
				REQ_PUSH_BACK: begin
					if (full_now) begin
						status_q <= STATUS_PUSH_FULL;
					end else begin
						back_q <= value_q;
						if (empty_now) begin
							front_q <= value_q;
						end
					end
				end
				REQ_POP_FRONT: begin
					if (empty_now) begin
						status_q <= STATUS_POP_EMPTY;
					end else begin
						popped_q <= front_q;
					end
				end
				REQ_POP_BACK: begin
					if (empty_now) begin
						status_q <= STATUS_POP_EMPTY;
					end else begin
						popped_q <= back_q;
					end
				end
				default: begin
					status_q <= STATUS_OK;
				end
			endcase
		end
		if (cmd.capture) begin
			if (req_q == REQ_POP_FRONT) begin
				front_q <= rd_data_q;
			end else begin
				back_q <= rd_data_q;
			end
		end
		if (cmd.out_load) begin
			popped_value  <= popped_q;
			front_value   <= empty_now ? '0 : front_q;
			back_value    <= empty_now ? '0 : back_q;
			element_count <= count_q;
			is_empty      <= empty_now;
			is_full       <= full_now;
			status        <= status_q;
		end
	end

endmodule

// ===== sv/double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque on a ring buffer; push or pop at either end per item.
// ---------------------------------------------------------------------------
// Each item steps the controller through accept, update and result load;
// a pop that leaves the queue non-empty adds a refill step, since the newly
// exposed end is fetched from the slot RAM with a registered read. The front and
// back elements are cached in flops, so pushes and the popped value never wait
// on the RAM. A new item is accepted while the previous result still waits on
// out_ready; its result load then waits until the older result is taken, and
// the input stays blocked meanwhile. Pop on empty reports status 1, push on
// full reports status 2; both leave the queue unchanged. No clearing pass is
// needed after reset.
`timescale 1ns / 1ps

module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  dq_pkg::req_t               req_type,
	input  logic [DATA_WIDTH-1:0]      push_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [DATA_WIDTH-1:0]      popped_value,
	output logic [DATA_WIDTH-1:0]      front_value,
	output logic [DATA_WIDTH-1:0]      back_value,
	output logic [$clog2(DEPTH+1)-1:0] element_count,
	output logic                       is_empty,
	output logic                       is_full,
	output dq_pkg::status_t            status
);
	import dq_pkg::*;

	dq_cmd_t cmd;
	dq_sts_t sts;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.push_value    (push_value),
		.popped_value  (popped_value),
		.front_value   (front_value),
		.back_value    (back_value),
		.element_count (element_count),
		.is_empty      (is_empty),
		.is_full       (is_full),
		.status        (status)
	);

endmodule

// ===== sv/dq_checker.sv =====
// ---------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque result channel, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module dq_checker #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [DATA_WIDTH-1:0]      popped_value,
	input logic [DATA_WIDTH-1:0]      front_value,
	input logic [DATA_WIDTH-1:0]      back_value,
	input logic [$clog2(DEPTH+1)-1:0] element_count,
	input logic                       is_empty,
	input logic                       is_full,
	input dq_pkg::status_t            status
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic                         flags_ok;
	logic                         ends_ok;
	logic                         reject_ok;
	logic                         stalled;
	logic [3*DATA_WIDTH+CW+3:0]   result_bits;

	assign flags_ok    = (is_empty == (element_count == '0)) &&
	                     (is_full == (element_count == CW'(DEPTH))) &&
	                     (element_count <= CW'(DEPTH));
	assign ends_ok     = !is_empty || (front_value == '0 && back_value == '0);
	assign reject_ok   = (status == STATUS_OK) || (popped_value == '0);
	assign stalled     = out_valid && !out_ready;
	assign result_bits = {popped_value, front_value, back_value, element_count,
	                      is_empty, is_full, status};

	`DQ_ASSERT(a_flags_match_count, !out_valid || flags_ok, "empty/full flags disagree with count")
	`DQ_ASSERT(a_empty_ends_zero, !out_valid || ends_ok, "empty queue shows nonzero end values")
	`DQ_ASSERT(a_reject_no_pop, !out_valid || reject_ok, "rejected item shows a popped value")
	`DQ_ASSERT_NEXT(a_result_held, stalled, out_valid && $stable(result_bits), "stalled result changed")

endmodule

bind double_ended_queue dq_checker #(
	.DEPTH      (DEPTH),
	.DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.popped_value  (popped_value),
	.front_value   (front_value),
	.back_value    (back_value),
	.element_count (element_count),
	.is_empty      (is_empty),
	.is_full       (is_full),
	.status        (status)
);

// ===== sim/dq_result_checker.sv =====
// ---------------------------------------------------------------------------
// dq_result_checker
// Watches both channels of the double-ended queue. Every accepted request is
// applied to a shadow ring buffer, and the response it should produce is
// queued. Every accepted response is compared field by field with the oldest
// queued one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_result_checker #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  dq_pkg::req_t               req_type,
	input  logic [DATA_WIDTH-1:0]      push_value,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [DATA_WIDTH-1:0]      popped_value,
	input  logic [DATA_WIDTH-1:0]      front_value,
	input  logic [DATA_WIDTH-1:0]      back_value,
	input  logic [$clog2(DEPTH+1)-1:0] element_count,
	input  logic                       is_empty,
	input  logic                       is_full,
	input  dq_pkg::status_t            status,
	output int                         fail_count,
	output int                         outstanding
);
	import dq_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [DATA_WIDTH-1:0] popped;
		logic [DATA_WIDTH-1:0] front;
		logic [DATA_WIDTH-1:0] back;
		logic [CW-1:0]         count;
		logic                  empty;
		logic                  full;
		status_t               status;
	} dq_result_t;

	logic [DATA_WIDTH-1:0] ring [DEPTH];
	logic [IW-1:0]         head_idx;
	logic [IW-1:0]         tail_idx;
	logic [CW-1:0]         fill;
	dq_result_t            expected_results [$];
	int                    failures = 0;
	int                    queued = 0;

	assign fail_count  = failures;
	assign outstanding = queued;

	function automatic logic [IW-1:0] step_fwd(logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [IW-1:0] step_back(logic [IW-1:0] i);
		return (i == '0) ? IW'(DEPTH - 1) : i - IW'(1);
	endfunction

	// applies one request to the shadow ring and returns the response it causes
	function automatic dq_result_t serve_request(req_t req, logic [DATA_WIDTH-1:0] val);
		dq_result_t res;
		res        = '0;
		res.status = STATUS_OK;
		case (req)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (fill == CW'(DEPTH)) begin
					res.status = STATUS_PUSH_FULL;
				end else if (req == REQ_PUSH_FRONT) begin
					head_idx       = step_back(head_idx);
					ring[head_idx] = val;
					fill           = fill + CW'(1);
				end else begin
					ring[tail_idx] = val;
					tail_idx       = step_fwd(tail_idx);
					fill           = fill + CW'(1);
				end
			end
			default: begin
				if (fill == '0) begin
					res.status = STATUS_POP_EMPTY;
				end else if (req == REQ_POP_FRONT) begin
					res.popped = ring[head_idx];
					head_idx   = step_fwd(head_idx);
					fill       = fill - CW'(1);
				end else begin
					tail_idx   = step_back(tail_idx);
					res.popped = ring[tail_idx];
					fill       = fill - CW'(1);
				end
			end
		endcase
		if (fill != '0) begin
			res.front = ring[head_idx];
			res.back  = ring[step_back(tail_idx)];
		end
		res.count = fill;
		res.empty = (fill == '0);
		res.full  = (fill == CW'(DEPTH));
		return res;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dq_result_t want;
		dq_result_t got;
		dq_result_t next_res;
		if (!arst_n) begin
			head_idx = '0;
			tail_idx = '0;
			fill     = '0;
			expected_results.delete();
			queued <= 0;
		end else begin
			// compare before queueing, so a new item never answers an older response
			if (out_valid && out_ready) begin
				got = {popped_value, front_value, back_value, element_count,
					is_empty, is_full, status};
				if (expected_results.size() == 0) begin
					$error("response accepted with no item pending");
					failures++;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					check_field("popped_value", 64'(want.popped), 64'(got.popped));
					check_field("front_value", 64'(want.front), 64'(got.front));
					check_field("back_value", 64'(want.back), 64'(got.back));
					check_field("element_count", 64'(want.count), 64'(got.count));
					check_field("is_empty", 64'(want.empty), 64'(got.empty));
					check_field("is_full", 64'(want.full), 64'(got.full));
					check_field("status", 64'(want.status), 64'(got.status));
				end
			end
			if (in_valid && in_ready) begin
				next_res = serve_request(req_type, push_value);
				expected_results.insert(expected_results.size(), next_res);
			end
			queued <= expected_results.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Drives the double-ended queue with a directed run over empty, full and
// wrap cases, then biased random requests in phases with and without idle
// cycles on either side, including a long output stall that backs up input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import dq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int DW           = 32;
	localparam int CW           = $clog2(DEPTH + 1);
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1720;

	logic          clk        = 1'b0;
	logic          arst_n     = 1'b0;
	logic          in_valid   = 1'b0;
	req_t          req_type   = REQ_PUSH_FRONT;
	logic [DW-1:0] push_value = '0;
	logic          out_ready  = 1'b0;
	logic          in_ready;
	logic          out_valid;
	logic [DW-1:0] popped_value;
	logic [DW-1:0] front_value;
	logic [DW-1:0] back_value;
	logic [CW-1:0] element_count;
	logic          is_empty;
	logic          is_full;
	status_t       status;

	int   fail_count;
	int   outstanding;
	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;
	logic hold_req     = 1'b0;
	logic hold_seen    = 1'b0;
	int   hold_left    = 0;
	int   quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	double_ended_queue #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DW)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.push_value    (push_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.popped_value  (popped_value),
		.front_value   (front_value),
		.back_value    (back_value),
		.element_count (element_count),
		.is_empty      (is_empty),
		.is_full       (is_full),
		.status        (status)
	);

	dq_result_checker #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DW)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.push_value    (push_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.popped_value  (popped_value),
		.front_value   (front_value),
		.back_value    (back_value),
		.element_count (element_count),
		.is_empty      (is_empty),
		.is_full       (is_full),
		.status        (status),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// receiver: random stalls, plus a long hold-off each time hold_req toggles
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input req_t r, input logic [DW-1:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= r;
		push_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	initial begin
		int            push_pct;
		int            bit_pos;
		req_t          r;
		logic [DW-1:0] val;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on empty, both extremes through both ends, then fill past full
		send_item(REQ_POP_FRONT, '1);
		send_item(REQ_POP_BACK, '0);
		send_item(REQ_PUSH_FRONT, '1);
		send_item(REQ_PUSH_BACK, '0);
		send_item(REQ_POP_FRONT, '0);
		send_item(REQ_POP_BACK, '1);
		for (int i = 0; i < DEPTH; i++)
			send_item(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom);
		send_item(REQ_PUSH_FRONT, '1);
		send_item(REQ_PUSH_BACK, '0);

		push_pct = 50;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					tx_idle_pct = 47;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 47;
				end
				default: begin
					tx_idle_pct = 17;
					rx_stall_pct <= 17;
				end
			endcase
			if (phase == 0 || phase == 3)
				hold_req <= ~hold_req;
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				// bias pushes against pops in runs so the fill level sweeps empty to full
				if (n % 32 == 0) begin
					case ($urandom_range(5))
						0: push_pct = 10;
						1: push_pct = 90;
						2: push_pct = 97;
						3: push_pct = 3;
						default: push_pct = 50;
					endcase
				end
				bit_pos = $urandom_range(DW - 1);
				case ($urandom_range(7))
					0: val = '0;
					1: val = '1;
					2: val = DW'(1) << bit_pos;
					3: val = ~(DW'(1) << bit_pos);
					default: val = $urandom;
				endcase
				if ($urandom_range(99) < push_pct)
					r = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
				else
					r = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
				send_item(r, val);
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
